[rtl/core/sobel_edge_threshold_defines.svh]
// ----------------------------------------------------------------------------
// sobel edge threshold assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_DEFINES_SVH

// assertion that is switched off while reset is low
`define SOBET_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that is checked during reset as well
`define SOBET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sobet_pkg.sv]
// ----------------------------------------------------------------------------
// sobet_pkg
// shared types, widths and register codes of the sobel edge threshold block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sobet_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned SQ_W       = 20;
  localparam int unsigned MAG_W      = 21;
  localparam int unsigned LIM_W      = 23;
  localparam int unsigned MIN_SIZE   = 3;

  localparam int unsigned OBUF_DEPTH = 8;
  localparam int unsigned OBUF_IDX_W = $clog2(OBUF_DEPTH);
  localparam int unsigned OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  localparam logic [THR_W-1:0]  THR_RST    = 11'd0;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic             edge_res;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/sobet_intf.sv]
// ----------------------------------------------------------------------------
// sobet interfaces
// pixel input channel and edge result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sobet_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sobet_pkg::PIX_W-1:0] pixel;
  logic                        frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sobet_res_if;
  logic                        valid;
  logic                        ready;
  logic                        edge_res;
  logic [sobet_pkg::POS_W-1:0] out_row;
  logic [sobet_pkg::POS_W-1:0] out_col;
  logic                        frame_last;

  modport source (
    output valid, output edge_res, output out_row, output out_col, output frame_last,
    input ready
  );
  modport sink (
    input valid, input edge_res, input out_row, input out_col, input frame_last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/sobet_ram.sv]
// ----------------------------------------------------------------------------
// sobet_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old entry on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/sobet_pos.sv]
// ----------------------------------------------------------------------------
// sobet_pos
// raster position counters, line store address and result position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobet_pos #(
  parameter int unsigned MaxWidth  = 2048,
  parameter int unsigned MaxHeight = 2048
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic                           frame_start_i,
  input  wire logic [sobet_pkg::SIZE_W-1:0]   width_i,
  input  wire logic [sobet_pkg::SIZE_W-1:0]   height_i,
  output logic      [$clog2(MaxWidth)-1:0]    addr_o,
  output sobet_pkg::pos_t                     pos_o
);

  import sobet_pkg::*;

  localparam int unsigned AW   = $clog2(MaxWidth);
  localparam int unsigned HW   = $clog2(MaxHeight);
  localparam int unsigned MAXM = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int unsigned XW   = $clog2(MAXM + (1 << SIZE_W));

  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [AW-1:0] c;
  logic [HW-1:0] r;
  logic [HW-1:0] r_m1;
  logic [AW-1:0] c_m1;
  logic [XW-1:0] w_eff, h_eff, w_x, h_x, c_nxt, r_nxt;
  logic          col_end, row_end;

  always_comb begin
    w_x = XW'(width_i);
    h_x = XW'(height_i);
    priority if (w_x < XW'(MIN_SIZE)) begin
      w_eff = XW'(MIN_SIZE);
    end else if (w_x > XW'(MaxWidth)) begin
      w_eff = XW'(MaxWidth);
    end else begin
      w_eff = w_x;
    end
    priority if (h_x < XW'(MIN_SIZE)) begin
      h_eff = XW'(MIN_SIZE);
    end else if (h_x > XW'(MaxHeight)) begin
      h_eff = XW'(MaxHeight);
    end else begin
      h_eff = h_x;
    end
  end

  assign c       = frame_start_i ? '0 : col_q;
  assign r       = frame_start_i ? '0 : row_q;
  assign c_nxt   = XW'(c) + XW'(1);
  assign r_nxt   = XW'(r) + XW'(1);
  assign col_end = c_nxt >= w_eff;
  assign row_end = r_nxt >= h_eff;
  assign r_m1    = r - HW'(1);
  assign c_m1    = c - AW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : HW'(r_nxt);
      end else begin
        col_d = AW'(c_nxt);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign addr_o     = c;
  assign pos_o.emit = (r >= HW'(2)) && (c >= AW'(2));
  assign pos_o.last = (c_nxt == w_eff) && (r_nxt == h_eff);
  assign pos_o.row  = POS_W'(r_m1);
  assign pos_o.col  = POS_W'(c_m1);

endmodule

`default_nettype wire

[rtl/core/sobet_grad.sv]
// ----------------------------------------------------------------------------
// sobet_grad
// 3x3 window, sobel gradients, squared magnitude and threshold compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobet_grad (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [sobet_pkg::PIX_W-1:0]  up_i,
  input  wire logic [sobet_pkg::PIX_W-1:0]  mid_i,
  input  wire logic [sobet_pkg::PIX_W-1:0]  px_i,
  input  wire sobet_pkg::pos_t              pos_i,
  input  wire logic [sobet_pkg::THR_W-1:0]  thr_i,
  output logic                              push_o,
  output sobet_pkg::res_t                   res_o,
  output logic      [1:0]                   pend_o
);

  import sobet_pkg::*;

  // p1 is the previous column, p2 the one before it; index 0 top row
  logic [PIX_W-1:0] p1_q [3];
  logic [PIX_W-1:0] p2_q [3];

  logic [PIX_W+1:0] gx_p, gx_m, gy_p, gy_m;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0] sqx_q, sqy_q;
  logic [THR_W:0] thr_p1;
  logic [2*THR_W+1:0] lim_full;
  logic [LIM_W-1:0] lim_q;
  logic [MAG_W-1:0] mag;

  logic s2_v_q, s3_v_q;
  pos_t s2_pos_q, s3_pos_q;

  assign gx_p = {2'b00, up_i} + {1'b0, mid_i, 1'b0} + {2'b00, px_i};
  assign gx_m = {2'b00, p2_q[0]} + {1'b0, p2_q[1], 1'b0} + {2'b00, p2_q[2]};
  assign gy_p = {2'b00, p2_q[2]} + {1'b0, p1_q[2], 1'b0} + {2'b00, px_i};
  assign gy_m = {2'b00, p2_q[0]} + {1'b0, p1_q[0], 1'b0} + {2'b00, up_i};
  assign gx_d = $signed({1'b0, gx_p}) - $signed({1'b0, gx_m});
  assign gy_d = $signed({1'b0, gy_p}) - $signed({1'b0, gy_m});

  assign gx_sq    = gx_q * gx_q;
  assign gy_sq    = gy_q * gy_q;
  assign thr_p1   = {1'b0, thr_i} + (THR_W + 1)'(1);
  assign lim_full = thr_p1 * thr_p1;

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p2_q[0] <= p1_q[0];
      p2_q[1] <= p1_q[1];
      p2_q[2] <= p1_q[2];
      p1_q[0] <= up_i;
      p1_q[1] <= mid_i;
      p1_q[2] <= px_i;
    end
    gx_q     <= gx_d;
    gy_q     <= gy_d;
    s2_pos_q <= pos_i;
    sqx_q    <= gx_sq[SQ_W-1:0];
    sqy_q    <= gy_sq[SQ_W-1:0];
    lim_q    <= lim_full[LIM_W-1:0];
    s3_pos_q <= s2_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s2_v_q <= valid_i;
      s3_v_q <= s2_v_q;
    end
  end

  assign mag              = MAG_W'(sqx_q) + MAG_W'(sqy_q);
  assign push_o           = s3_v_q && s3_pos_q.emit;
  assign res_o.edge_res   = LIM_W'(mag) >= lim_q;
  assign res_o.out_row    = s3_pos_q.row;
  assign res_o.out_col    = s3_pos_q.col;
  assign res_o.frame_last = s3_pos_q.last;
  assign pend_o           = {1'b0, s2_v_q && s2_pos_q.emit} + {1'b0, push_o};

endmodule

`default_nettype wire

[rtl/core/sobet_obuf.sv]
// ----------------------------------------------------------------------------
// sobet_obuf
// result buffer between the datapath and the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobet_obuf (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire sobet_pkg::res_t                 push_data_i,
  sobet_res_if.source                          res,
  output logic [sobet_pkg::OBUF_CNT_W-1:0]     count_o
);

  import sobet_pkg::*;

  res_t                  buf_q [OBUF_DEPTH];
  logic [OBUF_IDX_W-1:0] wr_q, rd_q;
  logic [OBUF_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;
  res_t                  head;

  assign pop  = res.valid && res.ready;
  assign head = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OBUF_CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - OBUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + OBUF_IDX_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + OBUF_IDX_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign res.valid      = cnt_q != '0;
  assign res.edge_res   = head.edge_res;
  assign res.out_row    = head.out_row;
  assign res.out_col    = head.out_col;
  assign res.frame_last = head.frame_last;
  assign count_o        = cnt_q;

endmodule

`default_nettype wire

[rtl/core/sobel_edge_threshold.sv]
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// streaming 3x3 sobel edge detector with magnitude threshold
// ----------------------------------------------------------------------------
// pixels arrive on pix in raster order; frame_start marks row 0, column 0.
// for each interior centre (row-1, col-1) one item leaves on res when the
// pixel at (row, col) with row and col at least 2 is taken; border pixels
// give no item. edge_res is 1 when the squared sobel gradient reaches
// (threshold + 1) squared; frame_last flags the last interior centre.
// throughput: one pixel per clock while pix.ready is high, set by the single
// read and single write port of each line store ram, which a column reads
// and writes back once; a result passes s1, s2, s3 and the result buffer.
// registers (cfg_we_i, cfg_idx_i, cfg_data_i): threshold, width, height;
// width and height saturate into 3..MaxWidth and 3..MaxHeight.
// a stalled receiver fills an eight-entry result buffer; pix.ready drops
// once buffered plus in-flight results reach eight, and no item is lost.
// reset clears the position counters and loads the register defaults;
// the line stores are not cleared and fill during the first two rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold #(
  parameter int unsigned MaxWidth  = 2048,
  parameter int unsigned MaxHeight = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  sobet_pix_if.sink                             pix,
  sobet_res_if.source                           res,
  input  wire logic                             cfg_we_i,
  input  wire logic [sobet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sobet_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import sobet_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);

  logic [THR_W-1:0]  thr_q;
  logic [SIZE_W-1:0] width_q, height_q;

  logic              accept;
  logic [AW-1:0]     rd_addr;
  pos_t              pos;

  logic              s1_v_q;
  logic [PIX_W-1:0]  s1_px_q;
  logic [AW-1:0]     s1_addr_q;
  pos_t              s1_pos_q;
  logic              fwd_q;
  logic [PIX_W-1:0]  fwd_up_q, fwd_mid_q;

  logic [PIX_W-1:0]  up_rd, mid_rd, up_eff, mid_eff;

  logic              push;
  res_t              push_data;
  logic [1:0]        pend;
  logic [OBUF_CNT_W-1:0] buf_cnt;
  logic [OBUF_CNT_W:0]   occ;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        REG_WIDTH:     width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_HEIGHT:    height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // results in flight plus buffered must leave room for one more
  assign occ       = (OBUF_CNT_W + 1)'(s1_v_q && s1_pos_q.emit) + (OBUF_CNT_W + 1)'(pend)
                   + (OBUF_CNT_W + 1)'(buf_cnt);
  assign pix.ready = occ < (OBUF_CNT_W + 1)'(OBUF_DEPTH);
  assign accept    = pix.valid && pix.ready;

  sobet_pos #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (pix.frame_start),
    .width_i       (width_q),
    .height_i      (height_q),
    .addr_o        (rd_addr),
    .pos_o         (pos)
  );

  // forward the write-back of the item in stage 1 to a read of the same column
  always_ff @(posedge clk_i) begin
    s1_px_q   <= pix.pixel;
    s1_addr_q <= rd_addr;
    s1_pos_q  <= pos;
    fwd_up_q  <= mid_eff;
    fwd_mid_q <= s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      s1_v_q <= accept;
      fwd_q  <= accept && s1_v_q && (s1_addr_q == rd_addr);
    end
  end

  assign up_eff  = fwd_q ? fwd_up_q  : up_rd;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rd;

  sobet_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_eff),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (up_rd)
  );

  sobet_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (mid_rd)
  );

  sobet_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .up_i    (up_eff),
    .mid_i   (mid_eff),
    .px_i    (s1_px_q),
    .pos_i   (s1_pos_q),
    .thr_i   (thr_q),
    .push_o  (push),
    .res_o   (push_data),
    .pend_o  (pend)
  );

  sobet_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .res         (res),
    .count_o     (buf_cnt)
  );

endmodule

`default_nettype wire

[rtl/core/sobet_chk.sv]
// ----------------------------------------------------------------------------
// sobet_chk
// port level checks of the sobel edge threshold block, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sobel_edge_threshold_defines.svh"

module sobet_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic                        res_edge,
  input wire logic [sobet_pkg::POS_W-1:0] res_row,
  input wire logic [sobet_pkg::POS_W-1:0] res_col,
  input wire logic                        res_last
);

  `SOBET_ASSERT_ALWAYS(a_no_item_in_reset, clk_i, !rst_ni |=> !res_valid, "item shown during reset")
  `SOBET_ASSERT(a_valid_held, clk_i, rst_ni, res_valid && !res_ready |=> res_valid, "item dropped while stalled")
  `SOBET_ASSERT(a_item_held, clk_i, rst_ni, res_valid && !res_ready |=> $stable(res_edge) && $stable(res_row) && $stable(res_col) && $stable(res_last), "item changed while stalled")
  `SOBET_ASSERT(a_interior_only, clk_i, rst_ni, res_valid |-> res_row != '0 && res_col != '0, "result for a border pixel")

endmodule

bind sobel_edge_threshold sobet_chk u_sobet_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_edge  (res.edge_res),
  .res_row   (res.out_row),
  .res_col   (res.out_col),
  .res_last  (res.frame_last)
);

`default_nettype wire

[tb/sv/sobel_edge_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel edge checker
// follows the pixel, result and register traffic of the edge detector, runs
// its own line-store and window model per accepted pixel, and compares every
// accepted result field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------

module sobel_edge_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sobet_pix_if                             pix,
  sobet_res_if                             res,
  input  logic                             cfg_we_i,
  input  logic [sobet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sobet_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_count_o,
  output int unsigned                      checked_count_o,
  output int unsigned                      frame_end_count_o
);
  import sobet_pkg::*;

  localparam int unsigned LINE_LEN = 2048;
  localparam int unsigned ROW_MAX  = 2048;

  logic [PIX_W-1:0]  upper_line  [LINE_LEN];
  logic [PIX_W-1:0]  middle_line [LINE_LEN];
  logic [PIX_W-1:0]  win [3][3];
  logic [POS_W-1:0]  next_col;
  logic [POS_W-1:0]  next_row;
  logic [THR_W-1:0]  threshold;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  res_t              edge_q [$];
  res_t              oldest;
  logic              bad;

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    int unsigned      mag2;
    int unsigned      lim;
    int               gx;
    int               gy;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    res_t             want;
    w = clamp_dim(width_reg, LINE_LEN);
    h = clamp_dim(height_reg, ROW_MAX);
    if (fs) begin
      next_col = '0;
      next_row = '0;
    end
    r = next_row;
    c = next_col;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    if (r >= 2 && c >= 2) begin
      gx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
         - int'(win[0][0]) - 2 * int'(win[1][0]) - int'(win[2][0]);
      gy = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2])
         - int'(win[0][0]) - 2 * int'(win[0][1]) - int'(win[0][2]);
      mag2 = gx * gx + gy * gy;
      lim = (int'(threshold) + 1) * (int'(threshold) + 1);
      want.edge_res = (mag2 >= lim);
      want.out_row = POS_W'(r - 1);
      want.out_col = POS_W'(c - 1);
      want.frame_last = (r == h - 1) && (c == w - 1);
      edge_q.push_back(want);
    end
    if (c + 1 >= w) begin
      next_col = '0;
      next_row = (r + 1 >= h) ? '0 : POS_W'(r + 1);
    end else begin
      next_col = POS_W'(c + 1);
    end
  endtask

  task automatic report_field(input string field, input int unsigned want_v,
                              input int unsigned got_v);
    $display("%0t sobel result %s: expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_col = '0;
      next_row = '0;
      threshold = THR_RST;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      edge_q.delete();
      pending_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: threshold = cfg_data_i[THR_W-1:0];
          REG_WIDTH: width_reg = cfg_data_i;
          REG_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      // results first, so an item taken on this edge is never matched to itself
      if (res.valid && res.ready) begin
        if (edge_q.size() == 0) begin
          $display("%0t sobel result: expected none, got edge %0d row %0d col %0d last %0d",
                   $time, res.edge_res, res.out_row, res.out_col, res.frame_last);
          mismatch_count_o++;
        end else begin
          oldest = edge_q.pop_front();
          bad = 1'b0;
          if (res.edge_res !== oldest.edge_res) begin
            report_field("edge_res", oldest.edge_res, res.edge_res);
            bad = 1'b1;
          end
          if (res.out_row !== oldest.out_row) begin
            report_field("out_row", oldest.out_row, res.out_row);
            bad = 1'b1;
          end
          if (res.out_col !== oldest.out_col) begin
            report_field("out_col", oldest.out_col, res.out_col);
            bad = 1'b1;
          end
          if (res.frame_last !== oldest.frame_last) begin
            report_field("frame_last", oldest.frame_last, res.frame_last);
            bad = 1'b1;
          end
          if (bad) mismatch_count_o++;
          checked_count_o++;
          if (oldest.frame_last) frame_end_count_o++;
        end
      end
      if (pix.valid && pix.ready) predict_pixel(pix.pixel, pix.frame_start);
      pending_count_o = edge_q.size();
    end
  end

endmodule

[tb/sv/sobel_edge_threshold_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel edge threshold testbench
// drives raster pixel streams through the edge detector: a few hand-built
// windows around the threshold boundary, the start of the widest and tallest
// frames, then many small random frames with size and threshold changes,
// mid-frame size cuts, stray frame starts, random stalls on both sides and
// one long output hold; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------

module sobel_edge_threshold_tb;
  import sobet_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 420;

  // left column bright, right dark: steepest horizontal gradient
  localparam logic [PIX_W-1:0] FALLING_COLUMNS [9] = '{
    8'd255, 8'd128, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd128, 8'd0
  };
  // gx = 6, gy = 8: squared magnitude exactly 100
  localparam logic [PIX_W-1:0] GRADIENT_SIX_EIGHT [9] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd4, 8'd0
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  quiet = 1'b0;
  logic                  hold_req = 1'b0;
  logic                  hold_served = 1'b0;
  logic                  need_fs = 1'b0;
  int unsigned           cur_w = WIDTH_RST;
  int unsigned           cur_h = HEIGHT_RST;
  int unsigned           items_sent = 0;
  int unsigned           cfg_writes = 0;
  int unsigned           cycle_count = 0;
  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           checked;
  int unsigned           frame_ends;

  sobet_pix_if pix_if ();
  sobet_res_if res_if ();

  always #5 clk_i = ~clk_i;

  sobel_edge_threshold #(
    .MaxWidth (2048),
    .MaxHeight(2048)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix       (pix_if),
    .res       (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  sobel_edge_checker u_edge_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix              (pix_if),
    .res              (res_if),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .checked_count_o  (checked),
    .frame_end_count_o(frame_ends)
  );

  function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > 2048) return 2048;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style, input int base);
    int v;
    case (style)
      0: v = $urandom_range(0, 255);
      1: v = base + int'($urandom_range(0, 24)) - 12;
      default: v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  // a wider line than before holds unwritten store entries, so restart the frame
  task automatic set_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    if (effective_size(w) > cur_w) need_fs = 1'b1;
    cur_w = effective_size(w);
    cur_h = effective_size(h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.pixel = px;
    pix_if.frame_start = fs;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
    if (fs) need_fs = 1'b0;
    items_sent++;
  endtask

  task automatic settle();
    pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic stream_pixels(input int unsigned count, input logic fs_first,
                               input int unsigned style, input logic noisy);
    int   base;
    logic fs;
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0 && fs_first) || need_fs || (noisy && $urandom_range(0, 199) == 0);
      send_pixel(pick_pixel(style, base), fs);
      if ($urandom_range(0, 15) == 0) base = $urandom_range(0, 255);
    end
  endtask

  task automatic send_pattern(input logic [PIX_W-1:0] pat [9], input logic fs_first);
    for (int i = 0; i < 9; i++) send_pixel(pat[i], i == 0 && fs_first);
  endtask

  initial begin : receiver
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sobel_edge_threshold_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned           rnd_start;
    int unsigned           phase;
    int unsigned           count;
    logic                  part_prev;
    logic [SIZE_W-1:0]     w_data;
    logic [SIZE_W-1:0]     h_data;
    logic [CFG_DATA_W-1:0] thr_data;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.frame_start = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // threshold left at its reset value for the first window
    set_sizes(12'd3, 12'd3);
    send_pattern(FALLING_COLUMNS, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, 12'd9);
    send_pattern(GRADIENT_SIX_EIGHT, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, 12'd10);
    send_pattern(GRADIENT_SIX_EIGHT, 1'b0);

    // start of the widest and tallest frames, the long side written above the saturation point
    settle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
    set_sizes(12'hFFF, 12'd3);
    stream_pixels(40, 1'b1, 1, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
    set_sizes(12'd0, 12'hFFF);
    stream_pixels(60, 1'b1, 1, 1'b0);

    rnd_start = items_sent;
    phase = 0;
    part_prev = 1'b0;
    while (items_sent - rnd_start < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0: thr_data = 12'd0;
        1: thr_data = 12'd1443;
        2: thr_data = 12'hFFF;
        3, 4: thr_data = CFG_DATA_W'($urandom_range(0, 300));
        default: thr_data = CFG_DATA_W'($urandom_range(0, 4095));
      endcase
      write_reg(REG_THRESHOLD, thr_data);
      if (part_prev && cur_w > 3 && $urandom_range(0, 1)) begin
        w_data = SIZE_W'($urandom_range(3, cur_w - 1));
      end else if ($urandom_range(0, 7) == 0) begin
        w_data = SIZE_W'($urandom_range(0, 2));
      end else begin
        w_data = SIZE_W'($urandom_range(3, 10));
      end
      if ($urandom_range(0, 7) == 0) begin
        h_data = SIZE_W'($urandom_range(0, 2));
      end else begin
        h_data = SIZE_W'($urandom_range(3, 8));
      end
      // a tall narrow frame under a long output hold fills the result buffer
      if (phase == 0) begin
        w_data = 12'd3;
        h_data = 12'd40;
        hold_req = 1'b1;
      end
      set_sizes(w_data, h_data);
      count = $urandom_range(1, 3) * cur_w * cur_h;
      part_prev = (phase != 0) && ($urandom_range(0, 2) == 0);
      if (part_prev) count += $urandom_range(1, cur_w * cur_h - 1);
      stream_pixels(count, $urandom_range(0, 3) != 0, $urandom_range(0, 2), 1'b1);
      phase++;
    end

    // closing frames with no idling on either side
    settle();
    quiet = 1'b1;
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
    set_sizes(12'd8, 12'd6);
    stream_pixels(96, 1'b1, 0, 1'b0);

    pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    $display("sobel run: %0d pixel items, %0d results checked, %0d frame ends, %0d reg writes",
             items_sent, checked, frame_ends, cfg_writes);
    $display("frames 3x3 to 10x8 plus a 40-row frame under a long hold, the first rows of %s",
             "2048-wide and 2048-tall frames, thresholds 0 to 2047, a closing run at full rate");
    if (mismatches == 0) begin
      $display("sobel_edge_threshold_tb: clean");
    end else begin
      $display("sobel_edge_threshold_tb: errors");
    end
    $finish;
  end

endmodule
